// ===== rtl/core/cbwt_pkg.sv =====
package cbwt_pkg;

	localparam int VERTEX_COUNT = 24;
	// usable vertex count, held to 2..64
	localparam int VC = (VERTEX_COUNT < 2) ? 2 : ((VERTEX_COUNT > 64) ? 64 : VERTEX_COUNT);
	localparam int IDX_W = $clog2(VC);

	localparam longint unsigned SEGS = longint'(VC - 1);
	localparam longint unsigned DEN = SEGS * SEGS * SEGS;

	localparam int COORD_W = 15;
	localparam int OFF_W = 8;
	localparam int CTRL_W = COORD_W + 1;
	localparam int WGT_W = 17;
	localparam int PROD_W = CTRL_W + WGT_W + 1;
	localparam int SUM_W = PROD_W + 1;
	localparam int FRAC_W = 8;
	localparam int POINT_W = 24;
	localparam int VIDX_W = 6;

	localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(32);
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CTRL_W-1:0] ctrl_t;
	typedef logic [OFF_W-1:0] off_t;
	typedef logic [WGT_W-1:0] weight_t;
	typedef weight_t [3:0] wrow_t;
	typedef wrow_t [VC-1:0] wtab_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [VIDX_W-1:0] vidx_t;
	typedef logic signed [POINT_W-1:0] point_t;

	typedef struct packed {
		logic valid;
		idx_t idx;
		logic last;
	} issue_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		vidx_t vertex_index;
		point_t point_x;
		point_t point_y;
		logic last_vertex;
	} vertex_t;

	// bernstein weights times 65536, rounded half up
	function automatic wrow_t weight_row(int unsigned i);
		longint unsigned t;
		longint unsigned o;
		longint unsigned num [4];
		wrow_t row;
		t = longint'(i);
		o = SEGS - t;
		num[0] = o * o * o;
		num[1] = 3 * o * o * t;
		num[2] = 3 * o * t * t;
		num[3] = t * t * t;
		for (int k = 0; k < 4; k++) begin
			row[k] = WGT_W'((num[k] * 65536 + DEN / 2) / DEN);
		end
		return row;
	endfunction

	function automatic wtab_t build_wtab();
		wtab_t tab;
		for (int i = 0; i < VC; i++) begin
			tab[i] = weight_row(i);
		end
		return tab;
	endfunction

	localparam wtab_t W_TAB = build_wtab();

endpackage

// ===== rtl/core/cbwt_if.sv =====
interface cbwt_cfg_if import cbwt_pkg::*; ();
	logic valid;
	logic ready;
	off_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbwt_in_if import cbwt_pkg::*; ();
	logic valid;
	logic ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

interface cbwt_out_if import cbwt_pkg::*; ();
	logic valid;
	logic ready;
	vidx_t vertex_index;
	point_t point_x;
	point_t point_y;
	logic last_vertex;
	modport source (output valid, output vertex_index, output point_x, output point_y,
		output last_vertex, input ready);
	modport sink (input valid, input vertex_index, input point_x, input point_y,
		input last_vertex, output ready);
endinterface

// ===== rtl/core/cubic_bezier_wire_tessellator_unit.sv =====
// cubic bezier wire tessellator
// points: one request carries a wire's start and end in integer pixels
// vertices: each request yields VERTEX_COUNT (24) curve points, one per
//   cycle while vertices is ready, x/y in signed fixed point with 8
//   fraction bits, the final one flagged with last_vertex
// cfg: writes control_offset, the horizontal pull of the inner control
//   points; always ready, write only while the block is idle
// first vertex: after its request is taken it passes the sequencer register
//   and then stages s1 to s4 before it shows valid; the vertex sequencer issues
//   one vertex a cycle, when not stalled, into a four-stage evaluation pipeline
// the next request is taken in the cycle the last vertex of the current one
//   issues, so requests stream back to back with no gap in the output
// reset: pipeline empties, sequencer goes idle, control_offset returns to 32
// stall: a low ready on a valid vertex freezes the whole pipeline and the
//   sequencer; the held vertex stays stable and nothing is dropped or repeated
module cubic_bezier_wire_tessellator_unit import cbwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	cbwt_cfg_if.sink cfg,
	cbwt_in_if.sink points,
	cbwt_out_if.source vertices
);

	off_t off_q;
	logic busy_q;
	idx_t idx_q;
	seg_t seg_q;
	logic adv;
	logic issue_last;
	logic take;
	issue_t issue;
	vertex_t vtx;

	// control offset register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OFF_RESET;
		end else if (cfg.valid) begin
			off_q <= cfg.data;
		end
	end

	// vertex sequencer: walks idx over 0..VC-1 for the held wire
	assign issue_last = (idx_q == IDX_W'(VC - 1));
	assign points.ready = !busy_q || (adv && issue_last);
	assign take = points.valid && points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && adv) begin
			if (issue_last) begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// wire endpoints held for the whole sweep
	always_ff @(posedge clk) begin
		if (take) begin
			seg_q.start_x <= points.start_x;
			seg_q.start_y <= points.start_y;
			seg_q.end_x <= points.end_x;
			seg_q.end_y <= points.end_y;
		end
	end

	assign issue.valid = busy_q;
	assign issue.idx = idx_q;
	assign issue.last = issue_last;

	// evaluation pipeline: lookup, multiply, pair add, final add and round
	cbwt_eval u_eval (
		.clk (clk),
		.arst_n (arst_n),
		.issue (issue),
		.seg (seg_q),
		.ctrl_off (off_q),
		.adv (adv),
		.vtx_valid (vertices.valid),
		.vtx_ready (vertices.ready),
		.vtx (vtx)
	);

	assign vertices.vertex_index = vtx.vertex_index;
	assign vertices.point_x = vtx.point_x;
	assign vertices.point_y = vtx.point_y;
	assign vertices.last_vertex = vtx.last_vertex;

endmodule

// ===== rtl/core/cbwt_eval.sv =====
module cbwt_eval import cbwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input issue_t issue,
	input seg_t seg,
	input off_t ctrl_off,
	output logic adv,
	output logic vtx_valid,
	input logic vtx_ready,
	output vertex_t vtx
);

	logic v_s1, v_s2, v_s3, v_s4;
	idx_t idx_s1, idx_s2, idx_s3, idx_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	ctrl_t x_s1 [4];
	ctrl_t y_s1 [4];
	wrow_t w_s1;
	logic signed [PROD_W-1:0] px_s2 [4];
	logic signed [PROD_W-1:0] py_s2 [4];
	logic signed [SUM_W-1:0] ax_s3, bx_s3, ay_s3, by_s3;
	point_t px_s4, py_s4;
	logic signed [SUM_W-1:0] sx, sy;

	assign adv = !v_s4 || vtx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: control points and weight lookup
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= issue.idx;
			last_s1 <= issue.last;
			x_s1[0] <= CTRL_W'(seg.start_x);
			x_s1[1] <= CTRL_W'(seg.start_x) + ctrl_t'({1'b0, ctrl_off});
			x_s1[2] <= CTRL_W'(seg.end_x) - ctrl_t'({1'b0, ctrl_off});
			x_s1[3] <= CTRL_W'(seg.end_x);
			y_s1[0] <= CTRL_W'(seg.start_y);
			y_s1[1] <= CTRL_W'(seg.start_y);
			y_s1[2] <= CTRL_W'(seg.end_y);
			y_s1[3] <= CTRL_W'(seg.end_y);
			w_s1 <= W_TAB[issue.idx];
		end
	end

	// s2: weighted terms
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
			for (int k = 0; k < 4; k++) begin
				px_s2[k] <= x_s1[k] * $signed({1'b0, w_s1[k]});
				py_s2[k] <= y_s1[k] * $signed({1'b0, w_s1[k]});
			end
		end
	end

	// s3: pair sums
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
			ax_s3 <= SUM_W'(px_s2[0]) + SUM_W'(px_s2[1]);
			bx_s3 <= SUM_W'(px_s2[2]) + SUM_W'(px_s2[3]);
			ay_s3 <= SUM_W'(py_s2[0]) + SUM_W'(py_s2[1]);
			by_s3 <= SUM_W'(py_s2[2]) + SUM_W'(py_s2[3]);
		end
	end

	// s4: final sum, round half up, drop fraction bits
	assign sx = ax_s3 + bx_s3 + $signed(ROUND_HALF);
	assign sy = ay_s3 + by_s3 + $signed(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4 <= idx_s3;
			last_s4 <= last_s3;
			px_s4 <= sx[FRAC_W +: POINT_W];
			py_s4 <= sy[FRAC_W +: POINT_W];
		end
	end

	assign vtx_valid = v_s4;
	assign vtx.vertex_index = VIDX_W'(idx_s4);
	assign vtx.point_x = px_s4;
	assign vtx.point_y = py_s4;
	assign vtx.last_vertex = last_s4;

endmodule

// ===== rtl/core/cbwt_checker.sv =====
module cbwt_checker import cbwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input vidx_t vertex_index,
	input point_t point_x,
	input point_t point_y,
	input logic last_vertex
);

	vidx_t exp_q;

	// expected index of the next vertex on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (out_valid && out_ready) begin
			if (last_vertex) begin
				exp_q <= '0;
			end else begin
				exp_q <= exp_q + VIDX_W'(1);
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_index)
			&& $stable(point_x) && $stable(point_y) && $stable(last_vertex))
		else $error("vertex changed while stalled");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vertex_index == exp_q)
		else $error("vertex index out of sequence");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_vertex == (vertex_index == VIDX_W'(VC - 1)))
		else $error("last flag on wrong vertex");

	a_endpt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (vertex_index == '0 || last_vertex)
			|-> point_x[FRAC_W-1:0] == '0 && point_y[FRAC_W-1:0] == '0)
		else $error("endpoint vertex not on whole pixel");

endmodule

bind cubic_bezier_wire_tessellator_unit cbwt_checker u_cbwt_checker (
	.clk (clk),
	.arst_n (arst_n),
	.out_valid (vertices.valid),
	.out_ready (vertices.ready),
	.vertex_index (vertices.vertex_index),
	.point_x (vertices.point_x),
	.point_y (vertices.point_y),
	.last_vertex (vertices.last_vertex)
);

// ===== tb/tb_cubic_bezier_wire_tessellator_unit.sv =====
module tb_cubic_bezier_wire_tessellator_unit;
	import cbwt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// allowance for the request-to-first-vertex path, used in the final wait
	localparam int LATENCY = 4;
	// watchdog limit in cycles, this leaves lots of room
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 18;
	localparam int RANDOM_PHASES = 8;
	localparam int WIRES_PER_PHASE = 55;
	// stretches where neither side idles
	localparam int QUIET_WIRE_LO = 150;
	localparam int QUIET_WIRE_HI = 260;
	localparam int QUIET_CYCLE_LO = 5000;
	localparam int QUIET_CYCLE_HI = 8000;

	typedef enum logic {ROW_WIRE, ROW_OFFSET} row_kind_t;

	// one directed step: either a wire request or a control_offset write;
	// ends_typed rows carry the exact first and last vertex by hand
	typedef struct {
		row_kind_t kind;
		int pull;
		int sx;
		int sy;
		int ex;
		int ey;
		bit ends_typed;
		int first_x;
		int first_y;
		int last_x;
		int last_y;
	} stim_row_t;

	localparam int N_ROWS = 21;

	stim_row_t directed_rows [N_ROWS] = '{
		// reset value of control_offset (32) is in effect here
		'{ROW_WIRE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
		'{ROW_WIRE, 0, -16384, -16384, 16383, 16383, 1,
			-4194304, -4194304, 4194048, 4194048},
		'{ROW_WIRE, 0, 16383, 16383, -16384, -16384, 1,
			4194048, 4194048, -4194304, -4194304},
		'{ROW_WIRE, 0, -1, -1, -1, -1, 1, -256, -256, -256, -256},
		'{ROW_WIRE, 0, 100, -50, 400, 300, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 16383, -16384, 16383, -16384, 1,
			4194048, -4194304, 4194048, -4194304},
		// no pull at all: a straight cubic between the endpoints
		'{ROW_OFFSET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, -16384, 0, 16383, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 5, 7, 5, 7, 1, 1280, 1792, 1280, 1792},
		'{ROW_WIRE, 0, -300, 200, 300, -200, 0, 0, 0, 0, 0},
		// strongest pull, control points pushed past the coordinate range
		'{ROW_OFFSET, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 16383, 16383, -16384, -16384, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, -16384, -16384, 16383, 16383, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, -16384, 16383, -16384, 16383, 0, 0, 0, 0, 0},
		// alternating bit patterns
		'{ROW_WIRE, 0, 10922, -10923, -10923, 10922, 0, 0, 0, 0, 0},
		'{ROW_OFFSET, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 1, 1, 2, 2, 0, 0, 0, 0, 0},
		'{ROW_OFFSET, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, -1000, 500, 1000, -500, 0, 0, 0, 0, 0},
		'{ROW_WIRE, 0, 16383, 0, -16384, 0, 0, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	cbwt_cfg_if cfg_bus ();
	cbwt_in_if points_bus ();
	cbwt_out_if vertices_bus ();

	cubic_bezier_wire_tessellator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.points(points_bus),
		.vertices(vertices_bus)
	);

	// predictor's copy of control_offset
	off_t offset_reg;
	// vertices of the curve being predicted, before they go on the queue
	vertex_t curve_buf [VC];
	// expected vertices, oldest first
	vertex_t pending_vertices [$];

	int mismatch_count;
	int cycle_count;
	int wire_count;
	bit sender_quiet;

	// clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d vertices still expected",
				cycle_count, pending_vertices.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// vertex sink: stalls at random with an IDLE_PCT (18) percent chance, never inside the quiet window
	always @(posedge clk) begin
		vertices_bus.ready <= (cycle_count >= QUIET_CYCLE_LO && cycle_count < QUIET_CYCLE_HI)
			|| ($urandom_range(99) >= IDLE_PCT);
	end

	// bezier curve for one wire under the current control_offset; the four
	// bernstein weights are scaled by 65536 and rounded half up, the weighted
	// sum then drops 8 of its 16 fraction bits with round half up
	function automatic void bezier_curve_points(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		longint segs;
		longint den;
		longint o;
		longint t;
		longint pull;
		longint acc_x;
		longint acc_y;
		longint wgt [4];
		longint cx [4];
		longint cy [4];
		segs = VC - 1;
		den = segs * segs * segs;
		pull = offset_reg;
		// control points: start pulled right, end pulled left, same heights
		cx[0] = sx;
		cx[1] = cx[0] + pull;
		cx[3] = ex;
		cx[2] = cx[3] - pull;
		cy[0] = sy;
		cy[1] = cy[0];
		cy[3] = ey;
		cy[2] = cy[3];
		for (int i = 0; i < VC; i++) begin
			t = i;
			o = segs - t;
			wgt[0] = o * o * o;
			wgt[1] = 3 * o * o * t;
			wgt[2] = 3 * o * t * t;
			wgt[3] = t * t * t;
			acc_x = 0;
			acc_y = 0;
			for (int k = 0; k < 4; k++) begin
				wgt[k] = (wgt[k] * 65536 + den / 2) / den;
				acc_x += cx[k] * wgt[k];
				acc_y += cy[k] * wgt[k];
			end
			curve_buf[i].vertex_index = vidx_t'(i);
			// arithmetic shift floors, so the +128 gives round half up
			curve_buf[i].point_x = point_t'((acc_x + 128) >>> FRAC_W);
			curve_buf[i].point_y = point_t'((acc_y + 128) >>> FRAC_W);
			curve_buf[i].last_vertex = (i == VC - 1);
		end
	endfunction

	// hold off new requests until the last expected vertex is out
	task automatic drain_vertices();
		if (points_bus.valid) begin
			points_bus.valid <= 1'b0;
		end
		while (pending_vertices.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// control_offset is only written with the pipeline empty
	task automatic write_offset(off_t value);
		drain_vertices();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		offset_reg = value;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one wire request; valid stays high on return so back to back requests
	// need no second assignment in the same step
	task automatic send_wire(stim_row_t row);
		while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
			points_bus.valid <= 1'b0;
			@(posedge clk);
		end
		points_bus.valid <= 1'b1;
		points_bus.start_x <= coord_t'(row.sx);
		points_bus.start_y <= coord_t'(row.sy);
		points_bus.end_x <= coord_t'(row.ex);
		points_bus.end_y <= coord_t'(row.ey);
		do begin
			@(posedge clk);
		end while (!points_bus.ready);
		// request taken at this edge: queue up its whole curve
		bezier_curve_points(coord_t'(row.sx), coord_t'(row.sy), coord_t'(row.ex),
			coord_t'(row.ey));
		if (row.ends_typed) begin
			curve_buf[0].point_x = point_t'(row.first_x);
			curve_buf[0].point_y = point_t'(row.first_y);
			curve_buf[VC-1].point_x = point_t'(row.last_x);
			curve_buf[VC-1].point_y = point_t'(row.last_y);
		end
		foreach (curve_buf[i]) begin
			pending_vertices.push_back(curve_buf[i]);
		end
		wire_count++;
	endtask

	// corners and the rails show up often, otherwise anything in range
	function automatic int pick_coord();
		case ($urandom_range(9))
			0: return -16384;
			1: return 16383;
			2: return 0;
			3: return -1;
			default: return int'(coord_t'($urandom));
		endcase
	endfunction

	// vertex checker: every accepted vertex against the oldest expectation
	always @(posedge clk) begin
		vertex_t got;
		vertex_t want;
		if (arst_n && vertices_bus.valid && vertices_bus.ready) begin
			got.vertex_index = vertices_bus.vertex_index;
			got.point_x = vertices_bus.point_x;
			got.point_y = vertices_bus.point_y;
			got.last_vertex = vertices_bus.last_vertex;
			if (pending_vertices.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("%0t: unexpected vertex idx %0d x %0d y %0d last %0d", $realtime,
						got.vertex_index, $signed(got.point_x), $signed(got.point_y),
						got.last_vertex);
				end
				mismatch_count++;
			end else begin
				want = pending_vertices.pop_front();
				if (got.vertex_index !== want.vertex_index || got.point_x !== want.point_x
						|| got.point_y !== want.point_y
						|| got.last_vertex !== want.last_vertex) begin
					if (mismatch_count < 10) begin
						$display("%0t: vertex mismatch, expected idx %0d x %0d y %0d last %0d,",
							$realtime, want.vertex_index, $signed(want.point_x),
							$signed(want.point_y), want.last_vertex);
						$display("    got idx %0d x %0d y %0d last %0d", got.vertex_index,
							$signed(got.point_x), $signed(got.point_y), got.last_vertex);
					end
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t row;
		int mode;
		off_t phase_offset;
		// every input known from time zero
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		points_bus.valid = 1'b0;
		points_bus.start_x = '0;
		points_bus.start_y = '0;
		points_bus.end_x = '0;
		points_bus.end_y = '0;
		vertices_bus.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		wire_count = 0;
		sender_quiet = 1'b0;
		offset_reg = OFF_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: endpoints, rails, pull extremes
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_OFFSET) begin
				write_offset(off_t'(directed_rows[r].pull));
			end else begin
				send_wire(directed_rows[r]);
			end
		end

		// random part, a new pull per phase with both extremes among them
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: phase_offset = '0;
				1: phase_offset = '1;
				default: phase_offset = off_t'($urandom_range(255));
			endcase
			write_offset(phase_offset);
			for (int n = 0; n < WIRES_PER_PHASE; n++) begin
				sender_quiet = (wire_count >= QUIET_WIRE_LO && wire_count < QUIET_WIRE_HI);
				row = '{ROW_WIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
				mode = $urandom_range(3);
				if (mode == 0) begin
					// short wire in the middle of the canvas, one case in four
					row.sx = $urandom_range(8000) - 4000;
					row.sy = $urandom_range(8000) - 4000;
					row.ex = row.sx + $urandom_range(4000) - 2000;
					row.ey = row.sy + $urandom_range(4000) - 2000;
				end else begin
					row.sx = pick_coord();
					row.sy = pick_coord();
					row.ex = pick_coord();
					row.ey = pick_coord();
				end
				send_wire(row);
				// now and then let the pipeline run dry mid phase
				if ($urandom_range(59) == 0) begin
					drain_vertices();
				end
			end
		end

		drain_vertices();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cbwt_pkg.sv
rtl/core/cbwt_if.sv
rtl/core/cbwt_eval.sv
rtl/core/cubic_bezier_wire_tessellator_unit.sv
rtl/core/cbwt_checker.sv
tb/tb_cubic_bezier_wire_tessellator_unit.sv
